>>> src/rpa3_pkg.sv
// ----------------------------------------------------------------------------
// rpa3_pkg
// Shared types, constants and helper functions of the reflect-padding
// address generator.
// ----------------------------------------------------------------------------
package rpa3_pkg;

  localparam int MAX_SIZE   = 1024;
  localparam int MAX_OFFSET = 64;

  // Field widths.
  localparam int CFG_W   = 11;
  localparam int PIX_W   = 12;
  localparam int OFF_W   = 8;
  localparam int COORD_W = 10;
  localparam int IDX_W   = 30;
  localparam int SIZE_W  = 11;
  localparam int P_W     = 11;
  localparam int V_W     = 14;
  localparam int MAG_W   = 13;
  localparam int WIDE_W  = P_W + MAG_W;
  localparam int ZX_W    = COORD_W + SIZE_W;

  // The modulo reduction retires two quotient bits per pipeline stage.
  localparam int STEPS_PER_STG = 2;
  localparam int FOLD_STAGES   = (MAG_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int FOLD_LAT      = FOLD_STAGES + 1;
  localparam int BACK_LAT      = FOLD_LAT + 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 3'd0,
    REG_SIZE_Y = 3'd1,
    REG_SIZE_Z = 3'd2,
    REG_PAD_X  = 3'd3,
    REG_PAD_Y  = 3'd4,
    REG_PAD_Z  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0]        out_x;
    logic [PIX_W-1:0]        out_y;
    logic [PIX_W-1:0]        out_z;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   src_index;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [COORD_W-1:0] src_z;
  } out_item_t;

  // One axis after classification: distance magnitude, period, size and
  // a flag for an axis of size one.
  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [P_W-1:0]    period;
    logic [SIZE_W-1:0] n;
    logic              unit;
  } axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } job_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] raw);
    logic [SIZE_W-1:0] n;
    n = SIZE_W'(raw);
    if (raw == '0) begin
      n = SIZE_W'(1);
    end else if (raw > CFG_W'(MAX_SIZE)) begin
      n = SIZE_W'(MAX_SIZE);
    end
    return n;
  endfunction

  function automatic logic signed [V_W-1:0] clamp_offset(input logic signed [OFF_W-1:0] raw);
    logic signed [V_W-1:0] v;
    v = V_W'(raw);
    if (v > V_W'(MAX_OFFSET)) begin
      v = V_W'(MAX_OFFSET);
    end else if (v < -V_W'(MAX_OFFSET)) begin
      v = -V_W'(MAX_OFFSET);
    end
    return v;
  endfunction

endpackage

>>> src/rpa3_front.sv
// ----------------------------------------------------------------------------
// rpa3_front
// Holds the configuration registers and turns each accepted item into a job
// with one entry per axis: clamped size, reflection period and distance magnitude.
// ----------------------------------------------------------------------------
module rpa3_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rpa3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa3_pkg::CFG_W-1:0]      cfg_wdata,
  input  rpa3_pkg::in_item_t              item,
  output rpa3_pkg::job_t                  job
);
  import rpa3_pkg::*;

  logic [CFG_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [CFG_W-1:0] pad_x_r, pad_y_r, pad_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= CFG_W'(MAX_SIZE);
      size_y_r <= CFG_W'(MAX_SIZE);
      size_z_r <= CFG_W'(MAX_SIZE);
      pad_x_r  <= '0;
      pad_y_r  <= '0;
      pad_z_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_wdata;
        REG_SIZE_Y: size_y_r <= cfg_wdata;
        REG_SIZE_Z: size_z_r <= cfg_wdata;
        REG_PAD_X:  pad_x_r  <= cfg_wdata;
        REG_PAD_Y:  pad_y_r  <= cfg_wdata;
        REG_PAD_Z:  pad_z_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The mirror fold is symmetric about zero, so only the magnitude of the
  // distance from the volume origin is passed on.
  function automatic axis_t classify(input logic [PIX_W-1:0] pos,
                                     input logic [CFG_W-1:0] pad,
                                     input logic signed [OFF_W-1:0] off,
                                     input logic [CFG_W-1:0] size);
    axis_t a;
    logic signed [V_W-1:0] v;
    logic [SIZE_W-1:0] n;
    n = clamp_size(size);
    v = signed'(V_W'(pos)) - signed'(V_W'(pad)) + clamp_offset(off);
    a.mag    = (v < 0) ? MAG_W'(-v) : MAG_W'(v);
    a.period = P_W'({n, 1'b0} - (SIZE_W + 1)'(2));
    a.n      = n;
    a.unit   = (n == SIZE_W'(1));
    return a;
  endfunction

  assign job.x = classify(item.out_x, pad_x_r, item.off_x, size_x_r);
  assign job.y = classify(item.out_y, pad_y_r, item.off_y, size_y_r);
  assign job.z = classify(item.out_z, pad_z_r, item.off_z, size_z_r);

endmodule

>>> src/rpa3_queue.sv
// ----------------------------------------------------------------------------
// rpa3_queue
// Short FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module rpa3_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rpa3_pkg::job_t  push_data,
  input  logic            pop,
  output rpa3_pkg::job_t  pop_data,
  output logic            empty,
  output logic            full
);
  import rpa3_pkg::*;

  job_t              mem_r [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

>>> src/rpa3_fold.sv
// ----------------------------------------------------------------------------
// rpa3_fold
// Pipelined mirror fold of one axis: restoring modulo reduction by the
// period, two quotient bits a stage, then the reflection into [0, n).
// ----------------------------------------------------------------------------
module rpa3_fold (
  input  logic                         clk,
  input  rpa3_pkg::axis_t              axis,
  output logic [rpa3_pkg::COORD_W-1:0] coord
);
  import rpa3_pkg::*;

  logic [MAG_W-1:0]  stg_mag    [0:FOLD_STAGES-1];
  logic [P_W-1:0]    stg_period [0:FOLD_STAGES-1];
  logic [SIZE_W-1:0] stg_n      [0:FOLD_STAGES-1];
  logic              stg_unit   [0:FOLD_STAGES-1];

  logic [MAG_W-1:0]  mag_nxt    [0:FOLD_STAGES-1];
  logic [MAG_W-1:0]  mag_r      [0:FOLD_STAGES-1];
  logic [P_W-1:0]    period_r   [0:FOLD_STAGES-1];
  logic [SIZE_W-1:0] n_r        [0:FOLD_STAGES-1];
  logic              unit_r     [0:FOLD_STAGES-1];

  logic [COORD_W-1:0] coord_r, coord_nxt;

  for (genvar s = 0; s < FOLD_STAGES; s++) begin : g_stg
    if (s == 0) begin : g_first
      assign stg_mag[s]    = axis.mag;
      assign stg_period[s] = axis.period;
      assign stg_n[s]      = axis.n;
      assign stg_unit[s]   = axis.unit;
    end else begin : g_next
      assign stg_mag[s]    = mag_r[s-1];
      assign stg_period[s] = period_r[s-1];
      assign stg_n[s]      = n_r[s-1];
      assign stg_unit[s]   = unit_r[s-1];
    end

    always_comb begin
      logic [WIDE_W-1:0] acc_w;
      logic [WIDE_W-1:0] div_w;
      int                k;
      acc_w = WIDE_W'(stg_mag[s]);
      div_w = '0;
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        k = MAG_W - 1 - STEPS_PER_STG * s - j;
        if (k >= 0) begin
          div_w = WIDE_W'(stg_period[s]) << k;
          if (acc_w >= div_w) begin
            acc_w = acc_w - div_w;
          end
        end
      end
      mag_nxt[s] = MAG_W'(acc_w);
    end

    always_ff @(posedge clk) begin
      mag_r[s]    <= mag_nxt[s];
      period_r[s] <= stg_period[s];
      n_r[s]      <= stg_n[s];
      unit_r[s]   <= stg_unit[s];
    end
  end

  // The remainder lies below the period; values in the upper half of the
  // period walk back down from the far edge.
  always_comb begin
    logic [MAG_W-1:0] m;
    m = mag_r[FOLD_STAGES-1];
    if (unit_r[FOLD_STAGES-1]) begin
      coord_nxt = '0;
    end else if (m >= MAG_W'(n_r[FOLD_STAGES-1])) begin
      coord_nxt = COORD_W'(period_r[FOLD_STAGES-1] - P_W'(m));
    end else begin
      coord_nxt = COORD_W'(m);
    end
  end

  always_ff @(posedge clk) begin
    coord_r <= coord_nxt;
  end

  assign coord = coord_r;

endmodule

>>> src/rpa3_back.sv
// ----------------------------------------------------------------------------
// rpa3_back
// Folds the three axes of each job and forms the linear source index
// through two registered multiply stages.
// ----------------------------------------------------------------------------
module rpa3_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  rpa3_pkg::job_t      job,
  output logic                out_valid,
  output rpa3_pkg::out_item_t out_data
);
  import rpa3_pkg::*;

  logic [COORD_W-1:0] fx, fy, fz;

  logic               vld_r  [0:BACK_LAT-1];
  logic [SIZE_W-1:0]  nx_d_r [0:FOLD_LAT-1];
  logic [SIZE_W-1:0]  ny_d_r [0:FOLD_LAT-1];

  logic [ZX_W-1:0]    zx_r, yx_r;
  logic [SIZE_W-1:0]  ny_r;
  logic [COORD_W-1:0] x1_r, y1_r, z1_r;
  logic [IDX_W-1:0]   zxy_r;
  logic [ZX_W:0]      lin_r;
  logic [COORD_W-1:0] x2_r, y2_r, z2_r;
  out_item_t          out_data_r;

  rpa3_fold u_fold_x (.clk(clk), .axis(job.x), .coord(fx));
  rpa3_fold u_fold_y (.clk(clk), .axis(job.y), .coord(fy));
  rpa3_fold u_fold_z (.clk(clk), .axis(job.z), .coord(fz));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= job_valid;
      for (int i = 1; i < BACK_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // The sizes ride alongside the fold pipeline to meet its result.
  always_ff @(posedge clk) begin
    nx_d_r[0] <= job.x.n;
    ny_d_r[0] <= job.y.n;
    for (int i = 1; i < FOLD_LAT; i++) begin
      nx_d_r[i] <= nx_d_r[i-1];
      ny_d_r[i] <= ny_d_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    zx_r  <= ZX_W'(fz * nx_d_r[FOLD_LAT-1]);
    yx_r  <= ZX_W'(fy * nx_d_r[FOLD_LAT-1]);
    ny_r  <= ny_d_r[FOLD_LAT-1];
    x1_r  <= fx;
    y1_r  <= fy;
    z1_r  <= fz;

    zxy_r <= IDX_W'(zx_r * ny_r);
    lin_r <= (ZX_W + 1)'(yx_r) + (ZX_W + 1)'(x1_r);
    x2_r  <= x1_r;
    y2_r  <= y1_r;
    z2_r  <= z1_r;

    out_data_r.src_index <= zxy_r + IDX_W'(lin_r);
    out_data_r.src_x     <= x2_r;
    out_data_r.src_y     <= y2_r;
    out_data_r.src_z     <= z2_r;
  end

  assign out_valid = vld_r[BACK_LAT-1];
  assign out_data  = out_data_r;

endmodule

>>> src/reflect_pad_address_3d.sv
// ----------------------------------------------------------------------------
// reflect_pad_address_3d
// Mirror-reflecting source address generator for a padded 3-D volume.
// ----------------------------------------------------------------------------
// An item is taken at every clock edge where start is high and busy is low,
// one item per clock. Its result appears on out_data with out_valid high for
// exactly one cycle, in order. The receiver cannot hold results off, so it
// must take each one in the cycle it is shown. The back end drains the job
// queue every cycle, so busy stays low in operation. An item passes one
// register in the job queue, seven modulo stages per axis (two quotient bits
// a stage over a 13-bit distance), one reflection register, two multiply
// stages and a final add for the linear index. Size and padding registers
// are written through cfg_we, cfg_index and cfg_wdata; the user must write
// them only while no item is in flight, as the block does not enforce it.
// ----------------------------------------------------------------------------
module reflect_pad_address_3d (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  rpa3_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output rpa3_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rpa3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa3_pkg::CFG_W-1:0]      cfg_wdata
);
  import rpa3_pkg::*;

  job_t front_job, queue_job;
  logic q_empty, q_full;

  rpa3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (in_data),
    .job       (front_job)
  );

  rpa3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !q_full),
    .push_data (front_job),
    .pop       (!q_empty),
    .pop_data  (queue_job),
    .empty     (q_empty),
    .full      (q_full)
  );

  rpa3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (queue_job),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = q_full;

endmodule

>>> tb/sv/reflect_pad_address_3d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflect_pad_address_3d_tb
// Self-checking bench for the mirror-reflecting 3-D address generator.
// A short table of directed probes covers the field extremes, offset
// saturation, unit, zero and oversized axes and padding beyond the volume.
// Random volumes and coordinates follow. Every result is compared field by
// field with a software fold of the same item or a value typed in the table.
// ----------------------------------------------------------------------------
module reflect_pad_address_3d_tb;
  import rpa3_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int MAX_GAP = 18;

  // The two register slots past the last defined one; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CFG_W-1:0] size_x;
    logic [CFG_W-1:0] size_y;
    logic [CFG_W-1:0] size_z;
    logic [CFG_W-1:0] pad_x;
    logic [CFG_W-1:0] pad_y;
    logic [CFG_W-1:0] pad_z;
  } vol_cfg_t;

  typedef struct {
    int        vol;
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } probe_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Copy of the volume registers as the block should hold them.
  logic [CFG_W-1:0] vol_size_x, vol_size_y, vol_size_z;
  logic [CFG_W-1:0] vol_pad_x, vol_pad_y, vol_pad_z;

  out_item_t  addr_q[$];
  probe_row_t probes[$];
  vol_cfg_t   vol_tab[6];
  bit         use_typed;
  out_item_t  typed_want;
  int         taken_cnt;
  int         quiet_cycles;
  int         err_cnt;
  int         steady_left;

  reflect_pad_address_3d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_size(input logic [CFG_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > MAX_SIZE) begin
      return MAX_SIZE;
    end
    return int'(raw);
  endfunction

  // Fold one axis into [0, n) by reflection with period 2n-2.
  function automatic int mirror_coord(input logic [PIX_W-1:0] pos,
                                      input logic [CFG_W-1:0] pad,
                                      input logic signed [OFF_W-1:0] off,
                                      input logic [CFG_W-1:0] size);
    int n, p, v, shift, padv, m;
    n = eff_size(size);
    shift = off;
    if (shift > MAX_OFFSET) begin
      shift = MAX_OFFSET;
    end else if (shift < -MAX_OFFSET) begin
      shift = -MAX_OFFSET;
    end
    padv = int'(pad);
    v = int'(pos) - padv + shift;
    if (n == 1) begin
      return 0;
    end
    p = 2 * n - 2;
    m = v % p;
    if (m < 0) begin
      m = m + p;
    end
    if (m >= n) begin
      m = p - m;
    end
    return m;
  endfunction

  function automatic out_item_t predict_address(input in_item_t it);
    out_item_t r;
    int x, y, z;
    longint unsigned nx, ny, idx;
    x = mirror_coord(it.out_x, vol_pad_x, it.off_x, vol_size_x);
    y = mirror_coord(it.out_y, vol_pad_y, it.off_y, vol_size_y);
    z = mirror_coord(it.out_z, vol_pad_z, it.off_z, vol_size_z);
    nx = eff_size(vol_size_x);
    ny = eff_size(vol_size_y);
    idx = longint'(z) * nx * ny + longint'(y) * nx + longint'(x);
    r.src_index = idx[IDX_W-1:0];
    r.src_x = x[COORD_W-1:0];
    r.src_y = y[COORD_W-1:0];
    r.src_z = z[COORD_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Result check, expectation capture and register shadowing, all at the edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (addr_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.src_index, 0);
      end else begin
        want = addr_q.pop_front();
        if (out_data.src_index !== want.src_index) begin
          report_mismatch("src_index", out_data.src_index, want.src_index);
        end
        if (out_data.src_x !== want.src_x) begin
          report_mismatch("src_x", out_data.src_x, want.src_x);
        end
        if (out_data.src_y !== want.src_y) begin
          report_mismatch("src_y", out_data.src_y, want.src_y);
        end
        if (out_data.src_z !== want.src_z) begin
          report_mismatch("src_z", out_data.src_z, want.src_z);
        end
      end
    end
    if (rst_n && start && !busy) begin
      addr_q.insert(addr_q.size(), use_typed ? typed_want : predict_address(in_data));
      taken_cnt <= taken_cnt + 1;
    end
    if (!rst_n) begin
      vol_size_x <= CFG_W'(MAX_SIZE);
      vol_size_y <= CFG_W'(MAX_SIZE);
      vol_size_z <= CFG_W'(MAX_SIZE);
      vol_pad_x  <= '0;
      vol_pad_y  <= '0;
      vol_pad_z  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: vol_size_x <= cfg_wdata;
        REG_SIZE_Y: vol_size_y <= cfg_wdata;
        REG_SIZE_Z: vol_size_z <= cfg_wdata;
        REG_PAD_X:  vol_pad_x  <= cfg_wdata;
        REG_PAD_Y:  vol_pad_y  <= cfg_wdata;
        REG_PAD_Z:  vol_pad_z  <= cfg_wdata;
        default: ;
      endcase
    end
    if ((rst_n && out_valid) || (rst_n && start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
    $display("[reflect_pad_address_3d] ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic drive_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    int seen;
    if (steady_left > 0) begin
      gap = 0;
      steady_left--;
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        steady_left = $urandom_range(10, 40);
      end
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data    <= it;
    use_typed  <= typed;
    typed_want <= want;
    start      <= 1'b1;
    seen = taken_cnt;
    do @(negedge clk); while (taken_cnt == seen);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (addr_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic program_volume(input vol_cfg_t c);
    write_reg(REG_SIZE_X, c.size_x);
    write_reg(REG_SIZE_Y, c.size_y);
    write_reg(REG_SIZE_Z, c.size_z);
    write_reg(REG_PAD_X, c.pad_x);
    write_reg(REG_PAD_Y, c.pad_y);
    write_reg(REG_PAD_Z, c.pad_z);
    write_reg(REG_SPARE_LO, CFG_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic add_probe(input int vol, input int ox, input int oy, input int oz,
                           input int fx, input int fy, input int fz,
                           input bit typed = 1'b0, input longint idx = 0,
                           input int sx = 0, input int sy = 0, input int sz = 0);
    probe_row_t r;
    r.vol = vol;
    r.item.out_x = PIX_W'(ox);
    r.item.out_y = PIX_W'(oy);
    r.item.out_z = PIX_W'(oz);
    r.item.off_x = OFF_W'(fx);
    r.item.off_y = OFF_W'(fy);
    r.item.off_z = OFF_W'(fz);
    r.typed = typed;
    r.want.src_index = IDX_W'(idx);
    r.want.src_x = COORD_W'(sx);
    r.want.src_y = COORD_W'(sy);
    r.want.src_z = COORD_W'(sz);
    probes.insert(probes.size(), r);
  endtask

  function automatic logic [CFG_W-1:0] draw_size();
    case ($urandom_range(0, 9))
      0: return CFG_W'(1);
      1: return CFG_W'(2);
      2: return CFG_W'(3);
      3: return CFG_W'(MAX_SIZE);
      4: return '0;
      5: return CFG_W'($urandom_range(MAX_SIZE + 1, 2047));
      default: return CFG_W'($urandom_range(1, MAX_SIZE));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] draw_pad();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'(1024);
      2: return CFG_W'(2047);
      3: return CFG_W'($urandom_range(0, 16));
      default: return CFG_W'($urandom_range(0, 1100));
    endcase
  endfunction

  // Coordinates cluster around the volume's edges part of the time, where
  // the fold changes direction.
  function automatic logic [PIX_W-1:0] draw_coord(input logic [CFG_W-1:0] pad,
                                                  input logic [CFG_W-1:0] size);
    int n;
    n = eff_size(size);
    if ($urandom_range(0, 9) < 4) begin
      return PIX_W'(int'(pad) + $urandom_range(0, 3 * n + 2));
    end
    return PIX_W'($urandom);
  endfunction

  function automatic logic signed [OFF_W-1:0] draw_offset();
    if ($urandom_range(0, 3) == 0) begin
      return OFF_W'($urandom);
    end
    return OFF_W'(int'($urandom_range(0, 2 * MAX_OFFSET)) - MAX_OFFSET);
  endfunction

  initial begin
    vol_cfg_t  c;
    in_item_t  it;
    out_item_t none;
    int        cur_vol;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    use_typed   = 1'b0;
    typed_want  = '0;
    taken_cnt   = 0;
    quiet_cycles = 0;
    err_cnt     = 0;
    steady_left = 0;
    none        = '0;

    vol_tab[0] = '{11'd1024, 11'd1024, 11'd1024, 11'd0, 11'd0, 11'd0};
    vol_tab[1] = '{11'd1, 11'd1, 11'd1, 11'd7, 11'd2047, 11'd0};
    vol_tab[2] = '{11'd0, 11'd0, 11'd0, 11'd1024, 11'd0, 11'd0};
    vol_tab[3] = '{11'd2047, 11'd2047, 11'd2047, 11'd0, 11'd0, 11'd0};
    vol_tab[4] = '{11'd2, 11'd3, 11'd5, 11'd2047, 11'd1024, 11'd3};
    vol_tab[5] = '{11'd1024, 11'd17, 11'd1, 11'd1024, 11'd64, 11'd1};

    // Reset volume: 1024 cubed, no padding.
    add_probe(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_probe(0, 1023, 1023, 1023, 0, 0, 0, 1, 64'h3FFF_FFFF, 1023, 1023, 1023);
    add_probe(0, 1024, 1024, 1024, 0, 0, 0, 1, 1072692222, 1022, 1022, 1022);
    add_probe(0, 0, 0, 0, -128, -128, -128, 1, 67174464, 64, 64, 64);
    add_probe(0, 0, 0, 0, 127, 127, 127, 1, 67174464, 64, 64, 64);
    add_probe(0, 0, 0, 0, -64, 64, -64, 1, 67174464, 64, 64, 64);
    add_probe(0, 4095, 4095, 4095, 0, 0, 0);
    add_probe(0, 2046, 2047, 2045, 0, 0, 0);
    add_probe(0, 100, 2000, 3071, 64, -64, 5);
    add_probe(0, 4095, 4095, 4095, 127, -128, 1);
    // Axes of size one collapse to zero.
    add_probe(1, 4095, 0, 123, -128, 127, 0, 1, 0, 0, 0, 0);
    add_probe(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    // A size of zero behaves as size one.
    add_probe(2, 555, 4095, 1, 64, -1, -64, 1, 0, 0, 0, 0);
    // Oversized axes saturate to the largest volume.
    add_probe(3, 1023, 1023, 1023, 0, 0, 0, 1, 64'h3FFF_FFFF, 1023, 1023, 1023);
    add_probe(3, 1024, 0, 0, 0, 0, 0);
    // Tiny axes with padding far outside the volume, then a mixed volume.
    add_probe(4, 0, 0, 0, 0, 0, 0);
    add_probe(4, 2047, 1024, 3, 0, 0, 0);
    add_probe(4, 2048, 1025, 4, 1, 1, 1);
    add_probe(4, 4095, 4095, 4095, -128, -128, -128);
    add_probe(4, 1, 2, 3, 127, 127, 127);
    add_probe(5, 0, 0, 0, -64, -64, -64);
    add_probe(5, 3071, 80, 7, 64, 64, 64);
    add_probe(5, 1024, 64, 1, 0, 0, 0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cur_vol = 0;
    foreach (probes[i]) begin
      if (probes[i].vol != cur_vol) begin
        wait_drained();
        cur_vol = probes[i].vol;
        program_volume(vol_tab[cur_vol]);
      end
      drive_item(probes[i].item, probes[i].typed, probes[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 0) begin
        c = '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024};
      end else if (ph == 1) begin
        c = '{11'd2, 11'd2, 11'd2, 11'd0, 11'd0, 11'd0};
      end else begin
        c.size_x = draw_size();
        c.size_y = draw_size();
        c.size_z = draw_size();
        c.pad_x  = draw_pad();
        c.pad_y  = draw_pad();
        c.pad_z  = draw_pad();
      end
      program_volume(c);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        it.out_x = draw_coord(c.pad_x, c.size_x);
        it.out_y = draw_coord(c.pad_y, c.size_y);
        it.out_z = draw_coord(c.pad_z, c.size_z);
        it.off_x = draw_offset();
        it.off_y = draw_offset();
        it.off_z = draw_offset();
        drive_item(it, 1'b0, none);
      end
    end

    wait_drained();
    repeat (2 * BACK_LAT + 8) @(negedge clk);
    if (addr_q.size() != 0) begin
      report_mismatch("results never delivered", 0, addr_q.size());
    end
    if (err_cnt == 0) begin
      $display("[reflect_pad_address_3d] OK");
    end else begin
      $display("[reflect_pad_address_3d] ERROR");
    end
    $finish;
  end

endmodule
